@@ hdl/card_uid_report_with_holdoff_macros.svh @@
// Assertion helpers for the RTL that checks itself.
`ifndef CARD_UID_REPORT_WITH_HOLDOFF_MACROS_SVH
`define CARD_UID_REPORT_WITH_HOLDOFF_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CUID_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CUID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/cuid_pkg.sv @@
`default_nettype none
package cuid_pkg;

	// Card event opcodes
	localparam logic [1:0] OP_READ_OK      = 2'd0;
	localparam logic [1:0] OP_READ_FAIL    = 2'd1;
	localparam logic [1:0] OP_READER_RESET = 2'd2;

	// Fixed characters of the report line
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_LC  = 8'h61;
	localparam logic [3:0] NIB_TEN  = 4'ha;

	localparam logic [7:0] HOLDOFF_RESET = 8'd10;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  uid_len;
		logic [63:0] uid_lo;
		logic [15:0] uid_hi;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       line_end;
	} out_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_DATA,
		BK_CR,
		BK_LF
	} back_state_t;

	// Lower-case hex digit of one nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < NIB_TEN) begin
			ch = CH_ZERO + {4'd0, nib};
		end else begin
			ch = CH_A_LC + {4'd0, nib - NIB_TEN};
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

@@ hdl/cuid_front.sv @@
`default_nettype none
module cuid_front #(
	parameter int MAX_UID_BYTES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  cuid_pkg::in_item_t in_data,
	output logic               job_valid,
	input  logic               job_ready,
	output logic [3:0]         job_len,
	output logic [MAX_UID_BYTES*8-1:0] job_uid
);
	import cuid_pkg::*;

	localparam int UID_W = MAX_UID_BYTES * 8;
	localparam logic [3:0] MAX_LEN = 4'(MAX_UID_BYTES);

	logic [7:0]       reload_q;
	logic [7:0]       holdoff_q;
	logic [3:0]       stored_len_q;
	logic [UID_W-1:0] stored_uid_q;

	logic [3:0]       len_c;
	logic [UID_W-1:0] uid_c;
	logic [7:0]       hold_dec_c;
	logic             same_c;
	logic             suppress_c;
	logic             accept_c;
	logic             read_ok_c;
	logic             forget_c;

	// Clamp length, take the bytes this build keeps
	assign len_c      = (in_data.uid_len > MAX_LEN) ? MAX_LEN : in_data.uid_len;
	assign uid_c      = UID_W'({in_data.uid_hi, in_data.uid_lo});
	assign hold_dec_c = holdoff_q - {7'd0, (holdoff_q != 8'd0)};

	// Compare against the stored UID over the valid bytes only
	always_comb begin
		same_c = (stored_len_q == len_c);
		for (int i = 0; i < MAX_UID_BYTES; i++) begin
			if ((4'(i) < len_c) && (uid_c[i*8 +: 8] != stored_uid_q[i*8 +: 8])) begin
				same_c = 1'b0;
			end
		end
	end

	assign suppress_c = (hold_dec_c != 8'd0) && same_c;
	assign in_ready   = job_ready;
	assign accept_c   = in_valid && in_ready;
	assign read_ok_c  = (in_data.opcode == OP_READ_OK);
	assign forget_c   = (in_data.opcode == OP_READ_FAIL) ||
	                    (in_data.opcode == OP_READER_RESET);
	assign job_valid  = accept_c && read_ok_c && !suppress_c;
	assign job_len    = len_c;
	assign job_uid    = uid_c;

	// Load the reload value; update holdoff and stored length on accepted events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q     <= HOLDOFF_RESET;
			holdoff_q    <= 8'd0;
			stored_len_q <= 4'd0;
		end else begin
			if (cfg_we) begin
				reload_q <= cfg_wdata;
			end
			if (accept_c && forget_c) begin
				stored_len_q <= 4'd0;
			end else if (accept_c && read_ok_c) begin
				if (suppress_c) begin
					holdoff_q <= hold_dec_c;
				end else begin
					holdoff_q    <= reload_q;
					stored_len_q <= len_c;
				end
			end
		end
	end

	// Keep the last reported UID
	always_ff @(posedge clk) begin
		if (job_valid) begin
			stored_uid_q <= uid_c;
		end
	end

endmodule
`default_nettype wire

@@ hdl/cuid_queue.sv @@
`default_nettype none
module cuid_queue #(
	parameter int WIDTH = 84
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import cuid_pkg::*;

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push_c;
	logic             pop_c;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push_c     = push_valid && push_ready;
	assign pop_c      = pop_valid && pop_ready;

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_c) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_c) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push_c} - {1'b0, pop_c};
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push_c) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ hdl/cuid_back.sv @@
`default_nettype none
module cuid_back #(
	parameter int MAX_UID_BYTES = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  logic [3:0]                 job_len,
	input  logic [MAX_UID_BYTES*8-1:0] job_uid,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cuid_pkg::out_item_t        out_data
);
	import cuid_pkg::*;

	localparam int UID_W = MAX_UID_BYTES * 8;
	localparam logic [4:0] HEAD_LAST = 5'd3;

	back_state_t      st_q, st_d;
	logic [4:0]       cnt_q, cnt_d;
	logic [3:0]       len_q, len_d;
	logic [UID_W-1:0] uid_q, uid_d;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             adv_c;
	logic             take_c;
	logic [4:0]       data_last_c;
	out_item_t        ch_c;

	assign adv_c       = (st_q != BK_IDLE) && (!out_valid_q || out_ready);
	assign take_c      = job_valid && job_ready;
	assign data_last_c = 5'({len_q, 1'b0}) - 5'd1;

	// Next state: walk header, data nibbles, CR, LF
	always_comb begin
		st_d  = st_q;
		cnt_d = cnt_q;
		len_d = len_q;
		uid_d = uid_q;
		unique case (st_q)
			BK_IDLE: begin
				if (take_c) begin
					st_d  = BK_HEAD;
					cnt_d = 5'd0;
					len_d = job_len;
					uid_d = job_uid;
				end
			end
			BK_HEAD: begin
				if (adv_c) begin
					if (cnt_q == HEAD_LAST) begin
						cnt_d = 5'd0;
						st_d  = (len_q == 4'd0) ? BK_CR : BK_DATA;
					end else begin
						cnt_d = cnt_q + 5'd1;
					end
				end
			end
			BK_DATA: begin
				if (adv_c) begin
					if (cnt_q[0]) begin
						uid_d = uid_q >> 8;
					end
					if (cnt_q == data_last_c) begin
						st_d = BK_CR;
					end else begin
						cnt_d = cnt_q + 5'd1;
					end
				end
			end
			BK_CR: begin
				if (adv_c) begin
					st_d = BK_LF;
				end
			end
			BK_LF: begin
				if (adv_c) begin
					if (take_c) begin
						st_d  = BK_HEAD;
						cnt_d = 5'd0;
						len_d = job_len;
						uid_d = job_uid;
					end else begin
						st_d = BK_IDLE;
					end
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	// Outputs: current character and job handshake
	always_comb begin
		ch_c      = '0;
		job_ready = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				job_ready = 1'b1;
			end
			BK_HEAD: begin
				unique case (cnt_q[1:0])
					2'd0:    ch_c.char_out = CH_R;
					2'd1:    ch_c.char_out = hex_digit(4'd0);
					2'd2:    ch_c.char_out = hex_digit(len_q);
					default: ch_c.char_out = CH_SPACE;
				endcase
			end
			BK_DATA: begin
				ch_c.char_out = hex_digit(cnt_q[0] ? uid_q[3:0] : uid_q[7:4]);
			end
			BK_CR: begin
				ch_c.char_out = CH_CR;
			end
			BK_LF: begin
				ch_c.char_out = CH_LF;
				ch_c.line_end = 1'b1;
				job_ready     = adv_c;
			end
			default: begin
				ch_c = '0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (adv_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the job and the output character
	always_ff @(posedge clk) begin
		len_q <= len_d;
		uid_q <= uid_d;
		if (adv_c) begin
			out_data_q <= ch_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

@@ hdl/card_uid_report_with_holdoff.sv @@
// Card UID reporter with repeat holdoff.
// in channel (in_valid/in_ready/in_data): one card event per item. Read-ok
// events that are not suppressed become report jobs; failed reads and reader
// resets only forget the stored UID; opcode 3 is ignored.
// out channel (out_valid/out_ready/out_data): one ASCII character per item,
// "R", length as two hex digits, space, two hex digits per UID byte, CR, LF;
// line_end marks the LF.
// cfg_we/cfg_wdata: holdoff reload value, reset 10.
// An accepted event's job passes the job queue and sequencer state before
// its first character is registered. The back-end sequencer sends one
// character per cycle while out_ready is high; lines follow without a gap.
// A two-entry job queue lets the front take events while a line is sent;
// in_ready drops only when that queue is full.
// A stalled receiver holds the output register; the sequencer waits with it.
// Reset: queue empty, no stored UID, holdoff counter zero, reload 10.
`default_nettype none
module card_uid_report_with_holdoff #(
	parameter int MAX_UID_BYTES = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  cuid_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cuid_pkg::out_item_t out_data
);
	import cuid_pkg::*;

	`include "card_uid_report_with_holdoff_macros.svh"

	localparam int UID_W = MAX_UID_BYTES * 8;
	localparam int JOB_W = UID_W + 4;

	logic             push_valid;
	logic             push_ready;
	logic [3:0]       push_len;
	logic [UID_W-1:0] push_uid;
	logic             pop_valid;
	logic             pop_ready;
	logic [JOB_W-1:0] pop_data;

	// Classify events and keep the holdoff state
	cuid_front #(
		.MAX_UID_BYTES(MAX_UID_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job_len   (push_len),
		.job_uid   (push_uid)
	);

	// Buffer report jobs between front and back
	cuid_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_len, push_uid}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Send the report line one character at a time
	cuid_back #(
		.MAX_UID_BYTES(MAX_UID_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job_len   (pop_data[JOB_W-1 -: 4]),
		.job_uid   (pop_data[UID_W-1:0]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`CUID_ASSERT_SAME(a_end_is_lf, out_valid && out_data.line_end, out_data.char_out == CH_LF, "line end on a character other than LF")
	`CUID_ASSERT_SAME(a_job_only_on_read, push_valid, in_valid && in_ready && (in_data.opcode == OP_READ_OK), "report job without an accepted read")
	`CUID_ASSERT_NEXT(a_job_reaches_queue, push_valid, pop_valid, "pushed job not visible in queue")

endmodule
`default_nettype wire
